// File: sv/button_multi_click_classifier_assert.svh
// assertion macros for the button gesture classifier
`ifndef BUTTON_MULTI_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_MULTI_CLICK_CLASSIFIER_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define BMC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define BMC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/bmc_pkg.sv
// shared types and constants for the button gesture classifier
package bmc_pkg;

   // field widths
   localparam int unsigned BTN_W   = 8;
   localparam int unsigned TICK_W  = 16;
   localparam int unsigned CNT_W   = 3;
   localparam int unsigned CFG_W   = 8;
   localparam int unsigned CSR_IDX_W = 2;

   // edge count limit and tick saturation value
   localparam logic [CNT_W-1:0]  EDGE_MAX = 3'd6;
   localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOUBLE_WAIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS   = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0] HOLD_TICKS_RST  = 8'd2;
   localparam logic [CFG_W-1:0] DOUBLE_WAIT_RST = 8'd4;
   localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 8'd2;

   // item kinds
   localparam logic REQ_BUTTON_EVENT = 1'b0;
   localparam logic REQ_TIMER_TICK   = 1'b1;

   // gesture codes
   typedef enum logic [2:0] {
      GEST_SINGLE_CLICK = 3'd0,
      GEST_SINGLE_HELD  = 3'd1,
      GEST_DOUBLE_CLICK = 3'd2,
      GEST_DOUBLE_HELD  = 3'd3,
      GEST_TRIPLE_CLICK = 3'd4,
      GEST_TRIPLE_HELD  = 3'd5
   } gesture_type;

   // thresholds from the register block
   typedef struct packed {
      logic [CFG_W-1:0] hold_ticks;
      logic [CFG_W-1:0] double_wait_ticks;
      logic [CFG_W-1:0] long_press_limit;
   } cfg_type;

   // classifier result for the item in the input register
   typedef struct packed {
      logic              valid;
      gesture_type       gesture;
      logic [BTN_W-1:0]  buttons;
   } res_type;

   // session status for checking
   typedef struct packed {
      logic              active;
      logic [CNT_W-1:0]  edge_count;
   } sts_type;

endpackage

// File: sv/bmc_if.sv
// channel interfaces for the button gesture classifier

// input items: button change or timer tick
interface bmc_req_if;
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [bmc_pkg::BTN_W-1:0] buttons;

   modport source (output valid, output req_type, output buttons, input ready);
   modport sink   (input valid, input req_type, input buttons, output ready);
endinterface

// result items: gesture and first mask
interface bmc_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [2:0]               gesture;
   logic [bmc_pkg::BTN_W-1:0] gesture_buttons;

   modport source (output valid, output gesture, output gesture_buttons, input ready);
   modport sink   (input valid, input gesture, input gesture_buttons, output ready);
endinterface

// register writes
interface bmc_csr_if;
   logic                         valid;
   logic                         ready;
   logic [bmc_pkg::CSR_IDX_W-1:0] index;
   logic [bmc_pkg::CFG_W-1:0]     wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: sv/bmc_cfg_regs.sv
// threshold registers written through the register port
module bmc_cfg_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [bmc_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [bmc_pkg::CFG_W-1:0]      wr_data,
   output bmc_pkg::cfg_type               cfg
);

   bmc_pkg::cfg_type cfg_ff;
   bmc_pkg::cfg_type cfg_in;

   // index decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            bmc_pkg::CSR_HOLD_TICKS:  cfg_in.hold_ticks        = wr_data;
            bmc_pkg::CSR_DOUBLE_WAIT: cfg_in.double_wait_ticks = wr_data;
            bmc_pkg::CSR_LONG_PRESS:  cfg_in.long_press_limit  = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_ticks        <= bmc_pkg::HOLD_TICKS_RST;
         cfg_ff.double_wait_ticks <= bmc_pkg::DOUBLE_WAIT_RST;
         cfg_ff.long_press_limit  <= bmc_pkg::LONG_PRESS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/bmc_classifier.sv
// session state and combinational gesture decision
module bmc_classifier (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       req_type,
   input  logic [bmc_pkg::BTN_W-1:0]  buttons,
   input  bmc_pkg::cfg_type           cfg,
   output bmc_pkg::res_type           res,
   output bmc_pkg::sts_type           sts
);

   logic                        active_ff,  active_in;
   logic [bmc_pkg::TICK_W-1:0]  ticks_ff,   ticks_in;
   logic [bmc_pkg::CNT_W-1:0]   count_ff,   count_in;
   logic [bmc_pkg::BTN_W-1:0]   first_ff,   first_in;
   logic [bmc_pkg::BTN_W-1:0]   last_ff;
   // of the edge times, only time1 and time3 are ever compared
   logic [bmc_pkg::TICK_W-1:0]  time1_ff,   time1_in;
   logic [bmc_pkg::TICK_W-1:0]  time3_ff,   time3_in;

   logic                        start;
   logic                        active_now;
   logic [bmc_pkg::TICK_W-1:0]  ticks_base;
   logic [bmc_pkg::CNT_W-1:0]   count_base;
   logic                        is_edge;
   logic                        take_edge;
   logic                        hold_hit;
   logic                        dwait_hit;
   logic                        end_sess;
   logic [bmc_pkg::TICK_W-1:0]  hold_ext, dwait_ext, limit_ext;

   assign hold_ext  = {{(bmc_pkg::TICK_W-bmc_pkg::CFG_W){1'b0}}, cfg.hold_ticks};
   assign dwait_ext = {{(bmc_pkg::TICK_W-bmc_pkg::CFG_W){1'b0}}, cfg.double_wait_ticks};
   assign limit_ext = {{(bmc_pkg::TICK_W-bmc_pkg::CFG_W){1'b0}}, cfg.long_press_limit};

   // session open, tick count and edge capture
   always_comb begin
      start      = !active_ff && (buttons != '0);
      active_now = active_ff || start;
      ticks_base = start ? '0 : ticks_ff;
      count_base = start ? '0 : count_ff;

      ticks_in = ticks_base;
      if (req_type == bmc_pkg::REQ_TIMER_TICK && ticks_base != bmc_pkg::TICK_MAX) begin
         ticks_in = ticks_base + 1'b1;
      end

      is_edge   = ((buttons == '0) && (last_ff != '0)) ||
                  ((buttons != '0) && (buttons != last_ff));
      take_edge = is_edge && (count_base < bmc_pkg::EDGE_MAX);

      count_in = take_edge ? count_base + 1'b1 : count_base;
      first_in = (take_edge && count_base == 3'd0) ? buttons : first_ff;
      time1_in = (take_edge && count_base == 3'd1) ? ticks_in : time1_ff;
      time3_in = (take_edge && count_base == 3'd3) ? ticks_in : time3_ff;

      hold_hit  = ticks_in >= hold_ext;
      dwait_hit = ticks_in >= dwait_ext;
   end

   // gesture decision on the updated edge count
   always_comb begin
      res.valid   = 1'b0;
      res.gesture = bmc_pkg::GEST_SINGLE_CLICK;
      res.buttons = first_in;
      end_sess    = 1'b0;
      case (count_in)
         3'd6: begin
            res.valid   = 1'b1;
            res.gesture = bmc_pkg::GEST_TRIPLE_CLICK;
            end_sess    = 1'b1;
         end
         3'd5: begin
            res.valid   = hold_hit;
            res.gesture = bmc_pkg::GEST_TRIPLE_HELD;
         end
         3'd4: begin
            res.gesture = bmc_pkg::GEST_DOUBLE_CLICK;
            if (time3_in > limit_ext) begin
               end_sess = 1'b1;
            end else if (dwait_hit) begin
               res.valid = 1'b1;
               end_sess  = 1'b1;
            end
         end
         3'd3: begin
            res.valid   = hold_hit;
            res.gesture = bmc_pkg::GEST_DOUBLE_HELD;
         end
         3'd2: begin
            res.gesture = bmc_pkg::GEST_SINGLE_CLICK;
            if (time1_in > limit_ext) begin
               end_sess = 1'b1;
            end else if (hold_hit) begin
               res.valid = 1'b1;
               end_sess  = 1'b1;
            end
         end
         3'd1: begin
            res.valid   = hold_hit;
            res.gesture = bmc_pkg::GEST_SINGLE_HELD;
         end
         default: ;
      endcase
      // no session, no result
      if (!active_now) begin
         res.valid = 1'b0;
         end_sess  = 1'b0;
      end
      active_in = active_now && !end_sess;
   end

   // session control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         ticks_ff  <= '0;
         count_ff  <= '0;
         first_ff  <= '0;
         last_ff   <= '0;
      end else if (step) begin
         last_ff <= buttons;
         if (active_now) begin
            active_ff <= active_in;
            first_ff  <= first_in;
            ticks_ff  <= end_sess ? '0 : ticks_in;
            count_ff  <= end_sess ? '0 : count_in;
         end
      end
   end

   // edge time store, meaningful only once written in the session
   always_ff @(posedge clock) begin
      if (step && active_now) begin
         time1_ff <= time1_in;
         time3_ff <= time3_in;
      end
   end

   assign sts.active     = active_ff;
   assign sts.edge_count = count_ff;

endmodule

// File: sv/button_multi_click_classifier.sv
// top level of the button gesture classifier
//
//  channel   dir   transfer when       payload
//  req_ch    in    valid && ready      req_type, buttons
//  rsp_ch    out   valid && ready      gesture, gesture_buttons
//  csr_ch    in    valid && ready      index, wdata (ready always high)
//
// one item per cycle while rsp is not stalled; rsp valid rises once the item has
// passed the input register and then the result register
// the item sits in an input register, the classifier updates state and the
// result register in one pass; an item without a gesture drops out there
// a stalled result register holds the input register, which holds req_ch
// reset is synchronous and clears session state and thresholds to defaults
`include "button_multi_click_classifier_assert.svh"

module button_multi_click_classifier (
   input  logic       clock,
   input  logic       reset,
   bmc_req_if.sink    req_ch,
   bmc_rsp_if.source  rsp_ch,
   bmc_csr_if.sink    csr_ch
);

   logic                       in_valid_ff,   in_valid_in;
   logic                       in_type_ff;
   logic [bmc_pkg::BTN_W-1:0]  in_buttons_ff;
   logic                       out_valid_ff,  out_valid_in;
   bmc_pkg::gesture_type       out_gesture_ff;
   logic [bmc_pkg::BTN_W-1:0]  out_buttons_ff;

   logic                       advance;
   logic                       step;
   logic                       req_xfer;
   logic                       out_load;
   bmc_pkg::cfg_type           cfg;
   bmc_pkg::res_type           res;
   bmc_pkg::sts_type           sts;

   // threshold registers
   bmc_cfg_regs u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.wdata),
      .cfg      (cfg)
   );
   assign csr_ch.ready = 1'b1;

   // pipeline handshake
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_load     = step && res.valid;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = advance ? out_load : out_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_type_ff    <= req_ch.req_type;
         in_buttons_ff <= req_ch.buttons;
      end
      if (out_load) begin
         out_gesture_ff <= res.gesture;
         out_buttons_ff <= res.buttons;
      end
   end

   // session tracking and gesture decision
   bmc_classifier u_cls (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req_type (in_type_ff),
      .buttons  (in_buttons_ff),
      .cfg      (cfg),
      .res      (res),
      .sts      (sts)
   );

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.gesture         = out_gesture_ff;
   assign rsp_ch.gesture_buttons = out_buttons_ff;

   // checks
   `BMC_ASSERT_IMPLY(a_idle_count_zero, clock, reset, !sts.active, sts.edge_count == 3'd0, "edge count nonzero outside a session")
   `BMC_ASSERT_ALWAYS(a_count_bound, clock, reset, sts.edge_count <= bmc_pkg::EDGE_MAX, "edge count past limit")
   `BMC_ASSERT_NEXT(a_triple_ends, clock, reset, out_load && res.gesture == bmc_pkg::GEST_TRIPLE_CLICK, !sts.active, "session open after triple click")
   `BMC_ASSERT_IMPLY(a_stall_holds_input, clock, reset, in_valid_ff && out_valid_ff && !rsp_ch.ready, !req_ch.ready, "input taken while result stalled")

endmodule

// File: tb/sv/tb_top.sv
// self-checking testbench for the button gesture classifier
`timescale 1ns / 100ps

module tb_top;
   import bmc_pkg::*;

   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_ITEMS   = 200;
   localparam int PHASES        = 8;
   localparam int DIR_ROWS      = 26;
   localparam int IDLE_PCT      = 22;
   localparam int PRINT_LIMIT   = 100;

   // how a directed row is checked
   typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_TYPED} row_check_type;

   typedef struct packed {
      logic             kind;
      logic [BTN_W-1:0] btn;
      row_check_type    chk;
      gesture_type      gest;
      logic [BTN_W-1:0] mask;
   } stim_row_type;

   typedef struct packed {
      gesture_type      gest;
      logic [BTN_W-1:0] mask;
   } gesture_rec_type;

   logic clock;
   logic reset;

   bmc_req_if req_ch ();
   bmc_rsp_if rsp_ch ();
   bmc_csr_if csr_ch ();

   button_multi_click_classifier uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // thresholds as the block should hold them
   logic [CFG_W-1:0]  thr_hold;
   logic [CFG_W-1:0]  thr_double;
   logic [CFG_W-1:0]  thr_long;

   // gesture tracker state
   logic              session_on;
   logic [TICK_W-1:0] sess_ticks;
   logic [CNT_W-1:0]  n_edges;
   logic [BTN_W-1:0]  first_btn;
   logic [BTN_W-1:0]  prev_btn;
   logic [TICK_W-1:0] edge_at [EDGE_MAX];

   gesture_rec_type   gesture_q [$];
   stim_row_type      dir_rows [DIR_ROWS];
   int                mismatches;
   bit                steady;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop
   initial begin
      #3000000;
      $display("FAIL button_multi_click_classifier");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("ERROR at %0t: %s", $time, msg);
   endtask

   function automatic void close_session();
      session_on = 1'b0;
      n_edges    = '0;
      sess_ticks = '0;
   endfunction

   // expected gesture for one item, updates tracker state
   task automatic classify_item(input logic kind, input logic [BTN_W-1:0] btn,
                                output bit fired, output gesture_rec_type res);
      bit moved;
      fired = 1'b0;
      res   = '0;
      if (!session_on && btn != 0) begin
         session_on = 1'b1;
         sess_ticks = '0;
         n_edges    = '0;
      end
      if (session_on) begin
         if (kind == REQ_TIMER_TICK && sess_ticks != TICK_MAX)
            sess_ticks = sess_ticks + 1'b1;
         moved = (btn == 0 && prev_btn != 0) || (btn != 0 && btn != prev_btn);
         if (moved && n_edges < EDGE_MAX) begin
            if (n_edges == 0)
               first_btn = btn;
            edge_at[n_edges] = sess_ticks;
            n_edges = n_edges + 1'b1;
         end
         case (n_edges)
            EDGE_MAX: begin
               fired    = 1'b1;
               res.gest = GEST_TRIPLE_CLICK;
               close_session();
            end
            3'd5: if (sess_ticks >= thr_hold) begin
               fired    = 1'b1;
               res.gest = GEST_TRIPLE_HELD;
            end
            3'd4: begin
               if (edge_at[3] > thr_long) begin
                  close_session();
               end else if (sess_ticks >= thr_double) begin
                  fired    = 1'b1;
                  res.gest = GEST_DOUBLE_CLICK;
                  close_session();
               end
            end
            3'd3: if (sess_ticks >= thr_hold) begin
               fired    = 1'b1;
               res.gest = GEST_DOUBLE_HELD;
            end
            3'd2: begin
               if (edge_at[1] > thr_long) begin
                  close_session();
               end else if (sess_ticks >= thr_hold) begin
                  fired    = 1'b1;
                  res.gest = GEST_SINGLE_CLICK;
                  close_session();
               end
            end
            3'd1: if (sess_ticks >= thr_hold) begin
               fired    = 1'b1;
               res.gest = GEST_SINGLE_HELD;
            end
            default: ;
         endcase
      end
      prev_btn = btn;
      res.mask = first_btn;
   endtask

   // one input transfer with random idling, then queue what it should produce
   task automatic issue_item(input logic kind, input logic [BTN_W-1:0] btn,
                             input row_check_type chk, input gesture_rec_type typed);
      bit              fired;
      gesture_rec_type res;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.buttons  <= btn;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      classify_item(kind, btn, fired, res);
      case (chk)
         CHK_MODEL: if (fired) gesture_q.push_back(res);
         CHK_TYPED: gesture_q.push_back(typed);
         default: ;
      endcase
   endtask

   // stop sending and wait until every expected gesture is out
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (gesture_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all three thresholds back to back
   task automatic program_thresholds(input logic [CFG_W-1:0] hold,
                                     input logic [CFG_W-1:0] dwait,
                                     input logic [CFG_W-1:0] limit);
      logic [CSR_IDX_W-1:0] idx [3];
      logic [CFG_W-1:0]     val [3];
      idx[0] = CSR_HOLD_TICKS;
      idx[1] = CSR_DOUBLE_WAIT;
      idx[2] = CSR_LONG_PRESS;
      val[0] = hold;
      val[1] = dwait;
      val[2] = limit;
      for (int i = 0; i < 3; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[i];
         csr_ch.wdata <= val[i];
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
         case (idx[i])
            CSR_HOLD_TICKS:  thr_hold   = val[i];
            CSR_DOUBLE_WAIT: thr_double = val[i];
            CSR_LONG_PRESS:  thr_long   = val[i];
            default: ;
         endcase
      end
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [BTN_W-1:0] pick_mask();
      if ($urandom_range(1))
         return 8'h01 << $urandom_range(1);
      return 8'($urandom_range(1, 255));
   endfunction

   // result side: check each transfer, stall at random
   always @(posedge clock) begin
      gesture_rec_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (gesture_q.size() == 0) begin
            report_mismatch($sformatf("unexpected gesture %0d buttons %02h",
                                      rsp_ch.gesture, rsp_ch.gesture_buttons));
         end else begin
            want = gesture_q.pop_front();
            if (rsp_ch.gesture !== want.gest)
               report_mismatch($sformatf("gesture %0d, expected %0d",
                                         rsp_ch.gesture, want.gest));
            if (rsp_ch.gesture_buttons !== want.mask)
               report_mismatch($sformatf("gesture_buttons %02h, expected %02h",
                                         rsp_ch.gesture_buttons, want.mask));
         end
      end
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   initial begin
      stim_row_type     row;
      gesture_rec_type  typed;
      logic             kind;
      logic [BTN_W-1:0] held;
      int               counted;
      int               r;
      bit               paused;

      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_BUTTON_EVENT;
      req_ch.buttons  = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = CSR_HOLD_TICKS;
      csr_ch.wdata    = '0;
      reset           = 1'b1;
      steady          = 1'b0;
      mismatches      = 0;
      paused          = 1'b0;
      held            = '0;

      thr_hold   = HOLD_TICKS_RST;
      thr_double = DOUBLE_WAIT_RST;
      thr_long   = LONG_PRESS_RST;
      session_on = 1'b0;
      sess_ticks = '0;
      n_edges    = '0;
      first_btn  = '0;
      prev_btn   = '0;
      for (int i = 0; i < EDGE_MAX; i++) edge_at[i] = '0;

      // directed rows under the reset thresholds
      // release with nothing open after reset
      dir_rows[0]  = '{REQ_BUTTON_EVENT, 8'h00, CHK_QUIET, GEST_SINGLE_CLICK, 8'h00};
      // press, hold until it fires, then release into a single click
      dir_rows[1]  = '{REQ_BUTTON_EVENT, 8'h01, CHK_QUIET, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[2]  = '{REQ_TIMER_TICK,   8'h01, CHK_QUIET, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[3]  = '{REQ_TIMER_TICK,   8'h01, CHK_TYPED, GEST_SINGLE_HELD,  8'h01};
      dir_rows[4]  = '{REQ_BUTTON_EVENT, 8'h00, CHK_TYPED, GEST_SINGLE_CLICK, 8'h01};
      // click, press and hold, then release into a double click
      dir_rows[5]  = '{REQ_BUTTON_EVENT, 8'h80, CHK_MODEL, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[6]  = '{REQ_BUTTON_EVENT, 8'h00, CHK_MODEL, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[7]  = '{REQ_BUTTON_EVENT, 8'h80, CHK_MODEL, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[8]  = '{REQ_TIMER_TICK,   8'h80, CHK_MODEL, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[9]  = '{REQ_TIMER_TICK,   8'h80, CHK_TYPED, GEST_DOUBLE_HELD,  8'h80};
      dir_rows[10] = '{REQ_BUTTON_EVENT, 8'h00, CHK_MODEL, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[11] = '{REQ_TIMER_TICK,   8'h00, CHK_QUIET, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[12] = '{REQ_TIMER_TICK,   8'h00, CHK_TYPED, GEST_DOUBLE_CLICK, 8'h80};
      // two clicks, a held third press, then release into a triple click
      dir_rows[13] = '{REQ_BUTTON_EVENT, 8'hFF, CHK_MODEL, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[14] = '{REQ_BUTTON_EVENT, 8'h00, CHK_MODEL, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[15] = '{REQ_BUTTON_EVENT, 8'h0F, CHK_MODEL, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[16] = '{REQ_BUTTON_EVENT, 8'h00, CHK_MODEL, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[17] = '{REQ_TIMER_TICK,   8'h00, CHK_MODEL, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[18] = '{REQ_TIMER_TICK,   8'h00, CHK_MODEL, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[19] = '{REQ_BUTTON_EVENT, 8'hF0, CHK_TYPED, GEST_TRIPLE_HELD,  8'hFF};
      dir_rows[20] = '{REQ_BUTTON_EVENT, 8'h00, CHK_TYPED, GEST_TRIPLE_CLICK, 8'hFF};
      // long press: hold repeats, late release drops the session
      dir_rows[21] = '{REQ_BUTTON_EVENT, 8'h55, CHK_MODEL, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[22] = '{REQ_TIMER_TICK,   8'h55, CHK_MODEL, GEST_SINGLE_CLICK, 8'h00};
      dir_rows[23] = '{REQ_TIMER_TICK,   8'h55, CHK_TYPED, GEST_SINGLE_HELD,  8'h55};
      dir_rows[24] = '{REQ_TIMER_TICK,   8'h55, CHK_TYPED, GEST_SINGLE_HELD,  8'h55};
      dir_rows[25] = '{REQ_BUTTON_EVENT, 8'h00, CHK_QUIET, GEST_SINGLE_CLICK, 8'h00};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part
      for (int i = 0; i < DIR_ROWS; i++) begin
         row        = dir_rows[i];
         typed.gest = row.gest;
         typed.mask = row.mask;
         issue_item(row.kind, row.btn, row.chk, typed);
      end
      drain_results();

      // random phases, each under its own thresholds
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: program_thresholds(8'd0, 8'd0, 8'd0);
            1: program_thresholds(8'd255, 8'd255, 8'd255);
            2: program_thresholds(HOLD_TICKS_RST, DOUBLE_WAIT_RST, LONG_PRESS_RST);
            5: program_thresholds(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  8'($urandom_range(255)));
            default: program_thresholds(8'($urandom_range(6)), 8'($urandom_range(10)),
                                        8'($urandom_range(6)));
         endcase
         steady  = (p == 2);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            // mostly press, release and tick sequences on a few masks
            r    = $urandom_range(99);
            kind = REQ_BUTTON_EVENT;
            if (r < 40) begin
               kind = REQ_TIMER_TICK;
            end else if (r < 52) begin
               held = '0;
            end else if (r < 72) begin
               held = pick_mask();
            end else if (r < 80) begin
               // same mask again, no edge
            end else if (r < 88) begin
               kind = REQ_TIMER_TICK;
               held = pick_mask();
            end else begin
               kind = $urandom_range(1) ? REQ_TIMER_TICK : REQ_BUTTON_EVENT;
               held = 8'($urandom_range(255));
            end
            counted++;
            issue_item(kind, held, CHK_MODEL, '0);
            // hold off mid-phase until the result side has caught up
            if (p == 4 && !paused && counted >= PHASE_ITEMS / 2) begin
               paused = 1'b1;
               drain_results();
            end
         end
         drain_results();
      end
      steady = 1'b0;

      if (mismatches == 0)
         $display("PASS button_multi_click_classifier");
      else
         $display("FAIL button_multi_click_classifier");
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/bmc_pkg.sv
sv/bmc_if.sv
sv/bmc_cfg_regs.sv
sv/bmc_classifier.sv
sv/button_multi_click_classifier.sv
tb/sv/tb_top.sv
